@@ rtl/core/ssum_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the subset sum search.
package ssum_pkg;

    localparam int DEF_MAX_ELEMENTS = 10;
    localparam int DEF_ELEMENT_BITS = 16;

    localparam int TARGET_W = 20;
    localparam int NUM_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [COUNT_W-1:0]  MAX_REPORTED = 7'd63;
    localparam logic [COUNT_W-1:0]  COUNT_OVF    = 7'd64;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 20'd1;

    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_TARGET = 1'b0;

    typedef struct packed {
        logic load;
        logic init;
        logic rd;
        logic set_bit;
        logic sol;
        logic incl;
        logic excl;
        logic pop;
        logic fix;
        logic sum;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic eq;
        logic incl_ok;
        logic excl_ok;
        logic at_root;
        logic bit_k;
        logic cnt_full;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/subset_sum_search.sv @@
`timescale 1ns / 1ps
// Top level of the subset sum search: stream ports, register port, controller and datapath.
//
//  channel   | direction | handshake              | content
//  s_axis    | in        | s_axis_tvalid/tready   | one set element, tlast starts the search
//  m_axis    | out       | m_axis_tvalid/tready   | one solution mask, or the closing summary
//  apb       | in/out    | psel/penable, pready=1 | target_sum at byte address 0
//
// Element beats are stored while idle; after the tlast beat the controller decides on a search.
// Each node is read, then tested, then given the exclude test; below the root, stepping back up pops
// the level and reads the parent again through the memory's registered read before undoing its sums.
// Reset clears the controller, the load count, the target and the output valid, not the element
// memory. A full output register stalls the walk in place, and input is refused from the tlast
// beat until the summary beat has been written.
module subset_sum_search #(
    parameter int MAX_ELEMENTS = ssum_pkg::DEF_MAX_ELEMENTS,
    parameter int ELEMENT_BITS = ssum_pkg::DEF_ELEMENT_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tdata: element_value
    input  logic [((ELEMENT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic                                  s_axis_tlast,
    // tdata: chosen_mask, solution_number, solutions_found, count_overflow
    output logic [((MAX_ELEMENTS + 2 * ssum_pkg::NUM_W + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tuser: is_summary
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ssum_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import ssum_pkg::*;

    localparam int OUT_DATA_W = ((MAX_ELEMENTS + 2 * NUM_W + 1 + 7) / 8) * 8;

    ssum_pkg::cmd_t cmd;
    ssum_pkg::sts_t sts;

    logic [TARGET_W-1:0]     target_reg;
    logic                    reg_hit;
    logic [MAX_ELEMENTS-1:0] out_mask;
    logic [NUM_W-1:0]        out_num;
    logic [NUM_W-1:0]        out_found;
    logic                    out_ovf;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_TARGET);
    assign prdata  = reg_hit ? 32'(target_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            target_reg <= pwdata[TARGET_W-1:0];
        end
    end

    ssum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssum_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .target      (target_reg),
        .in_value    (s_axis_tdata[ELEMENT_BITS-1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_mask    (out_mask),
        .out_num     (out_num),
        .out_summary (m_axis_tuser),
        .out_found   (out_found),
        .out_ovf     (out_ovf),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_W'({out_ovf, out_found, out_num, out_mask});

endmodule

@@ rtl/core/ssum_dp.sv @@
`timescale 1ns / 1ps
// Datapath: element memory, search registers, bounding tests and the output register.
module ssum_dp #(
    parameter int MAX_ELEMENTS = ssum_pkg::DEF_MAX_ELEMENTS,
    parameter int ELEMENT_BITS = ssum_pkg::DEF_ELEMENT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssum_pkg::cmd_t                cmd,
    output ssum_pkg::sts_t                sts,
    input  logic [ssum_pkg::TARGET_W-1:0] target,
    input  logic [ELEMENT_BITS-1:0]       in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [MAX_ELEMENTS-1:0]       out_mask,
    output logic [ssum_pkg::NUM_W-1:0]    out_num,
    output logic                          out_summary,
    output logic [ssum_pkg::NUM_W-1:0]    out_found,
    output logic                          out_ovf,
    output logic                          out_last
);
    import ssum_pkg::*;

    localparam int LVL_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = ELEMENT_BITS + $clog2(MAX_ELEMENTS);
    localparam int CMP_W = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 2;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(MAX_ELEMENTS - 1);

    logic [ELEMENT_BITS-1:0] store_mem [MAX_ELEMENTS];

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SUM_W-1:0]        total_reg, total_next;
    logic [ELEMENT_BITS-1:0] first_reg;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [SUM_W-1:0]        m_reg, m_next;
    logic [SUM_W-1:0]        rem_reg, rem_next;
    logic [MAX_ELEMENTS-1:0] path_reg, path_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [ELEMENT_BITS-1:0] sk_reg, sn_reg;

    logic                    out_valid_reg;
    logic [MAX_ELEMENTS-1:0] out_mask_reg;
    logic [NUM_W-1:0]        out_num_reg;
    logic                    out_summary_reg;
    logic [NUM_W-1:0]        out_found_reg;
    logic                    out_ovf_reg;
    logic                    out_last_reg;

    logic                    full;
    logic                    has_next;
    logic                    cnt_full;
    logic                    out_free;
    logic                    out_write;
    logic [LVL_W-1:0]        nxt_addr;
    logic [MAX_ELEMENTS-1:0] lvl_onehot;
    logic [MAX_ELEMENTS-1:0] low_mask;
    logic [SUM_W-1:0]        sk_ext;
    logic [CMP_W-1:0]        m_x, sk_x, sn_x, rem_x, t_x;

    assign full       = (cnt_reg == CNT_W'(MAX_ELEMENTS));
    assign has_next   = ((CNT_W'(lvl_reg) + CNT_W'(1)) < cnt_reg);
    assign cnt_full   = (count_reg >= MAX_REPORTED);
    assign out_free   = !out_valid_reg || out_ready;
    assign out_write  = (cmd.sol && !cnt_full) || cmd.sum;
    assign nxt_addr   = (lvl_reg == LAST_LVL) ? lvl_reg : lvl_reg + LVL_W'(1);
    assign lvl_onehot = MAX_ELEMENTS'(1) << lvl_reg;
    // Bits 0..k; the shift wraps to zero at the top level, which still gives all ones.
    assign low_mask   = (lvl_onehot << 1) - MAX_ELEMENTS'(1);
    assign sk_ext     = SUM_W'(sk_reg);

    // Element past the last loaded one reads as absent.
    assign m_x   = CMP_W'(m_reg);
    assign sk_x  = CMP_W'(sk_reg);
    assign sn_x  = has_next ? CMP_W'(sn_reg) : '0;
    assign rem_x = CMP_W'(rem_reg);
    assign t_x   = CMP_W'(target);

    assign sts.go       = (CMP_W'(total_reg) >= t_x) && (CMP_W'(first_reg) <= t_x);
    assign sts.eq       = ((m_x + sk_x) == t_x);
    assign sts.incl_ok  = has_next && ((m_x + sk_x + sn_x) <= t_x);
    assign sts.excl_ok  = has_next && ((m_x + rem_x - sk_x) >= t_x) && ((m_x + sn_x) <= t_x);
    assign sts.at_root  = (lvl_reg == '0);
    assign sts.bit_k    = |(path_reg & lvl_onehot);
    assign sts.cnt_full = cnt_full;
    assign sts.out_free = out_free;

    always_comb
    begin
        cnt_next   = cnt_reg;
        total_next = total_reg;
        lvl_next   = lvl_reg;
        m_next     = m_reg;
        rem_next   = rem_reg;
        path_next  = path_reg;
        count_next = count_reg;
        if (cmd.load && !full)
        begin
            cnt_next   = cnt_reg + CNT_W'(1);
            total_next = total_reg + SUM_W'(in_value);
        end
        if (cmd.init)
        begin
            lvl_next   = '0;
            m_next     = '0;
            rem_next   = total_reg;
            path_next  = '0;
            count_next = '0;
        end
        if (cmd.set_bit)
        begin
            path_next = path_next | lvl_onehot;
        end
        if (cmd.sol)
        begin
            count_next = cnt_full ? COUNT_OVF : count_reg + COUNT_W'(1);
        end
        if (cmd.incl)
        begin
            m_next   = m_reg + sk_ext;
            rem_next = rem_reg - sk_ext;
            lvl_next = lvl_reg + LVL_W'(1);
        end
        if (cmd.excl)
        begin
            path_next = path_next & ~lvl_onehot;
            rem_next  = rem_reg - sk_ext;
            lvl_next  = lvl_reg + LVL_W'(1);
        end
        if (cmd.pop)
        begin
            lvl_next = lvl_reg - LVL_W'(1);
        end
        // Coming back up: undo the child's sums. Only the include child added s[k] to m.
        if (cmd.fix)
        begin
            if (sts.bit_k)
            begin
                m_next = m_reg - sk_ext;
            end
            rem_next = rem_reg + sk_ext;
        end
        if (cmd.sum)
        begin
            cnt_next   = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg   <= lvl_next;
        m_reg     <= m_next;
        rem_reg   <= rem_next;
        path_reg  <= path_next;
        count_reg <= count_next;
        if (cmd.load && cnt_reg == '0)
        begin
            first_reg <= in_value;
        end
        if (cmd.sol && !cnt_full)
        begin
            out_mask_reg    <= (path_reg | lvl_onehot) & low_mask;
            out_num_reg     <= NUM_W'(count_reg + COUNT_W'(1));
            out_summary_reg <= 1'b0;
            out_found_reg   <= '0;
            out_ovf_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        if (cmd.sum)
        begin
            out_mask_reg    <= '0;
            out_num_reg     <= '0;
            out_summary_reg <= 1'b1;
            out_found_reg   <= (count_reg > MAX_REPORTED) ? NUM_W'(MAX_REPORTED)
                                                          : count_reg[NUM_W-1:0];
            out_ovf_reg     <= (count_reg > MAX_REPORTED);
            out_last_reg    <= 1'b1;
        end
    end

    // Element memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            store_mem[cnt_reg[LVL_W-1:0]] <= in_value;
        end
        if (cmd.rd)
        begin
            sk_reg <= store_mem[lvl_reg];
            sn_reg <= store_mem[nxt_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_mask    = out_mask_reg;
    assign out_num     = out_num_reg;
    assign out_summary = out_summary_reg;
    assign out_found   = out_found_reg;
    assign out_ovf     = out_ovf_reg;
    assign out_last    = out_last_reg;

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_write |-> out_free)
        else $error("result written while the output register is occupied");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (CNT_W'(lvl_reg) < cnt_reg))
        else $error("search level beyond the loaded elements");

    a_pop_above_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (lvl_reg != '0))
        else $error("backtrack below the root level");

    a_summary_closes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |=> (cnt_reg == '0) && out_valid_reg && out_last_reg && out_summary_reg)
        else $error("summary beat did not close the run");

endmodule

@@ rtl/core/ssum_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences loading and the backtracking walk.
module ssum_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  ssum_pkg::sts_t sts,
    output ssum_pkg::cmd_t cmd
);
    import ssum_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_START    = 9'b000000010,
        S_RD_ENTER = 9'b000000100,
        S_EVAL     = 9'b000001000,
        S_EXCL     = 9'b000010000,
        S_POP      = 9'b000100000,
        S_RD_RET   = 9'b001000000,
        S_FIX      = 9'b010000000,
        S_SUMMARY  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                // The hit count is cleared even when the set is hopeless, so the summary reads 0.
                cmd.init = 1'b1;
                if (sts.go)
                begin
                    state_next = S_RD_ENTER;
                end
                else
                begin
                    state_next = S_SUMMARY;
                end
            end
            S_RD_ENTER:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.set_bit = 1'b1;
                if (sts.eq)
                begin
                    // Past the reporting limit a hit is only counted, so it never waits.
                    if (sts.cnt_full || sts.out_free)
                    begin
                        cmd.sol    = 1'b1;
                        state_next = S_EXCL;
                    end
                end
                else if (sts.incl_ok)
                begin
                    cmd.incl   = 1'b1;
                    state_next = S_RD_ENTER;
                end
                else
                begin
                    state_next = S_EXCL;
                end
            end
            S_EXCL:
            begin
                if (sts.excl_ok)
                begin
                    cmd.excl   = 1'b1;
                    state_next = S_RD_ENTER;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sts.at_root)
                begin
                    state_next = S_SUMMARY;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_RD_RET;
                end
            end
            S_RD_RET:
            begin
                cmd.rd     = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                // A set bit means the include branch just finished; the exclude branch is next.
                state_next = sts.bit_k ? S_EXCL : S_POP;
            end
            S_SUMMARY:
            begin
                if (sts.out_free)
                begin
                    cmd.sum    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
